// ===== hw/rtl/hashed_timer_wheel_assert.svh =====
// Assertion macros shared by the hashed timer wheel RTL
`ifndef HASHED_TIMER_WHEEL_ASSERT_SVH
`define HASHED_TIMER_WHEEL_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that the antecedent implies the consequent in the same cycle
`define HTW_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hashed_timer_wheel: assertion failed");
// Check that a condition never holds
`define HTW_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("hashed_timer_wheel: assertion failed");
`else
`define HTW_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define HTW_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== hw/rtl/htw_pkg.sv =====
// Package with types and constants of the hashed timer wheel
`timescale 1ns / 1ps
package htw_pkg;

  localparam int SLOTS_DEF   = 256;
  localparam int ENTRIES_DEF = 32;

  localparam int TIMEOUT_W = 24;
  localparam int ACTION_W  = 8;
  localparam int HANDLE_W  = 16;
  localparam int ROUNDS_W  = 16;
  localparam int COUNT_W   = 6;
  localparam int TICK_W    = 32;
  localparam int DIV_CNT_W = 2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NOP    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    RES_ADD    = 2'd0,
    RES_CANCEL = 2'd1,
    RES_FIRE   = 2'd2,
    RES_DONE   = 2'd3
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan_run;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/hashed_timer_wheel.sv =====
// Top level of the hashed timer wheel: controller and datapath
//
// Request channel: req_valid/req_stall with req_type, action, handle and timeout.
//   An add places a timer in the lowest free pool entry, a cancel frees every
//   entry with the given handle, a tick advances the wheel by one slot.
// Result channel: res_valid/res_stall with result_kind, status, fired_action,
//   fired_handle, count, tick_now and last. Each add and cancel gives one result;
//   a tick gives one fired result per expiring timer with a nonzero handle,
//   in pool order, then a done result. last marks the final result of a request.
// Timing: one request at a time. Every add, cancel and tick sweeps the pool one
//   entry per cycle, while the reciprocal division of the timeout by SLOTS
//   (multiply, quotient, remainder) runs beside the sweep; the final result is
//   written once both are done. The next request is taken only after the final
//   result of the previous one is in the result register.
//   Fired results that the receiver stalls hold the sweep for as long as the
//   stall lasts.
// The result register lets a new request be accepted while the last result
//   still waits to be taken.
// Reset (rst, synchronous) empties the pool, clears the tick count and the
//   active count, and drops any pending result.
`timescale 1ns / 1ps
`include "hashed_timer_wheel_assert.svh"
module hashed_timer_wheel import htw_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           req_type,
  input  logic [ACTION_W-1:0]  action,
  input  logic [HANDLE_W-1:0]  handle,
  input  logic [TIMEOUT_W-1:0] timeout,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [1:0]           result_kind,
  output logic                 status,
  output logic [ACTION_W-1:0]  fired_action,
  output logic [HANDLE_W-1:0]  fired_handle,
  output logic [COUNT_W-1:0]   count,
  output logic [TICK_W-1:0]    tick_now,
  output logic                 last
);

  localparam logic [COUNT_W-1:0] ENTRIES_N = COUNT_W'(ENTRIES);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       res_fire;
  logic       res_done;

  htw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  htw_datapath #(
    .SLOTS   (SLOTS),
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .req_type     (req_type),
    .action       (action),
    .handle       (handle),
    .timeout      (timeout),
    .res_stall    (res_stall),
    .res_valid    (res_valid),
    .result_kind  (result_kind),
    .status       (status),
    .fired_action (fired_action),
    .fired_handle (fired_handle),
    .count        (count),
    .tick_now     (tick_now),
    .last         (last)
  );

  // Classify the result on offer
  assign res_fire = res_valid && (result_kind == RES_FIRE);
  assign res_done = res_valid && (result_kind == RES_DONE);

  // A fired timer always has an owner
  `HTW_ASSERT_IMPLY(a_fire_handle, clk, rst, res_fire, fired_handle != '0)
  // The final result is written only into a free result register
  `HTW_ASSERT_IMPLY(a_finish_free, clk, rst, cmd.finish, st.out_free)
  // The active count reported by a done result never exceeds the pool size
  `HTW_ASSERT_IMPLY(a_done_count, clk, rst, res_done, count <= ENTRIES_N)

endmodule

// ===== hw/rtl/htw_ctrl.sv =====
// Controller state machine of the hashed timer wheel
`timescale 1ns / 1ps
module htw_ctrl import htw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_type,
  output logic       req_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_kind_t'(req_type))
            REQ_ADD, REQ_CANCEL, REQ_TICK: state_next = ST_SCAN;
            default:                       state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (st.scan_done && st.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive commands and the input stall
  always_comb begin
    req_stall    = (state != ST_IDLE);
    cmd.load     = (state == ST_IDLE) && req_valid;
    cmd.scan_run = (state == ST_SCAN);
    cmd.finish   = (state == ST_FINISH) && st.out_free;
  end

endmodule

// ===== hw/rtl/htw_datapath.sv =====
// Datapath of the hashed timer wheel: pool, divider, scan and result register
`timescale 1ns / 1ps
module htw_datapath import htw_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           st,
  input  logic [1:0]           req_type,
  input  logic [ACTION_W-1:0]  action,
  input  logic [HANDLE_W-1:0]  handle,
  input  logic [TIMEOUT_W-1:0] timeout,
  input  logic                 res_stall,
  output logic                 res_valid,
  output logic [1:0]           result_kind,
  output logic                 status,
  output logic [ACTION_W-1:0]  fired_action,
  output logic [HANDLE_W-1:0]  fired_handle,
  output logic [COUNT_W-1:0]   count,
  output logic [TICK_W-1:0]    tick_now,
  output logic                 last
);

  localparam int SW = $clog2(SLOTS);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = 2 * TIMEOUT_W + 1;
  localparam int RECIP_SH = TIMEOUT_W + SW;
  localparam logic [SW:0]          SLOTS_X   = (SW + 1)'(SLOTS);
  localparam logic [SW-1:0]        SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [CW-1:0]        ENTRIES_C = CW'(ENTRIES);
  localparam logic [TIMEOUT_W-1:0] SLOTS_T   = TIMEOUT_W'(SLOTS);
  // Rounded-up reciprocal of SLOTS, exact for every 24-bit dividend
  localparam logic [TIMEOUT_W:0]   RECIP     = (TIMEOUT_W + 1)'(
    ((64'd1 << RECIP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
  localparam logic [DIV_CNT_W-1:0] DIV_MUL   = DIV_CNT_W'(0);
  localparam logic [DIV_CNT_W-1:0] DIV_QUO   = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_REM   = DIV_CNT_W'(2);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(3);

  // Request held for the duration of the transaction
  req_kind_t           req_kind;
  logic [ACTION_W-1:0] req_action;
  logic [HANDLE_W-1:0] req_handle;

  // Divider by SLOTS through the reciprocal, one stage per cycle
  logic [TIMEOUT_W-1:0] dvd;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        prod_sh;
  logic [TIMEOUT_W-1:0] quo;
  logic [TIMEOUT_W-1:0] back;
  logic [TIMEOUT_W-1:0] rem_full;
  logic [SW-1:0]        rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TIMEOUT_W-1:0] tm1;

  // Wheel position and occupancy
  logic [TICK_W-1:0]  tick_count;
  logic [SW-1:0]      cur_slot;
  logic [COUNT_W-1:0] active_total;
  logic [ENTRIES-1:0] valid_bits;

  // Entry pool
  logic [ACTION_W-1:0] mem_action [ENTRIES];
  logic [HANDLE_W-1:0] mem_handle [ENTRIES];
  logic [SW-1:0]       mem_slot   [ENTRIES];
  logic [ROUNDS_W-1:0] mem_rounds [ENTRIES];
  logic [ACTION_W-1:0] rd_action;
  logic [HANDLE_W-1:0] rd_handle;
  logic [SW-1:0]       rd_slot;
  logic [ROUNDS_W-1:0] rd_rounds;

  // Scan pipeline
  logic [CW-1:0]      idx;
  logic               eval_valid;
  logic [IW-1:0]      eval_ix;
  logic               found;
  logic [IW-1:0]      free_ix;
  logic [COUNT_W-1:0] cancel_cnt;

  logic scan_live, ev_vb, hit_tick, expire, emit_fire, hit_cancel, hit_free;
  logic out_free, advance, step, rd_en, add_commit;

  // New entry placement
  logic [SW:0]          slot_sum;
  logic [SW:0]          slot_sub;
  logic [SW-1:0]        slot_new;
  logic [ROUNDS_W-1:0]  rounds_new;

  // Timeout minus one, quotient out of the product and remainder
  always_comb begin
    tm1      = (timeout == '0) ? '0 : timeout - TIMEOUT_W'(1);
    prod_sh  = prod >> RECIP_SH;
    back     = quo * SLOTS_T;
    rem_full = dvd - back;
  end

  // Evaluate the entry read out of the pool
  always_comb begin
    scan_live  = cmd.scan_run && eval_valid;
    ev_vb      = valid_bits[eval_ix];
    hit_tick   = scan_live && (req_kind == REQ_TICK) && ev_vb && (rd_slot == cur_slot);
    expire     = hit_tick && (rd_rounds == '0);
    emit_fire  = expire && (rd_handle != '0);
    hit_cancel = scan_live && (req_kind == REQ_CANCEL) && ev_vb && (rd_handle == req_handle);
    hit_free   = scan_live && (req_kind == REQ_ADD) && !ev_vb && !found;
    out_free   = !res_valid || !res_stall;
    advance    = !(emit_fire && !out_free);
    step       = cmd.scan_run && advance;
    rd_en      = step && (idx != ENTRIES_C);
    add_commit = cmd.finish && (req_kind == REQ_ADD) && found;
  end

  // Place the new timer relative to the current slot
  always_comb begin
    slot_sum   = {1'b0, cur_slot} + {1'b0, rem} + (SW + 1)'(1);
    slot_sub   = slot_sum - SLOTS_X;
    slot_new   = (slot_sum >= SLOTS_X) ? slot_sub[SW-1:0] : slot_sum[SW-1:0];
    rounds_new = (|quo[TIMEOUT_W-1:ROUNDS_W]) ? '1 : quo[ROUNDS_W-1:0];
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_kind <= REQ_NOP;
    end else if (cmd.load) begin
      req_kind <= req_kind_t'(req_type);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_handle <= handle;
    end
  end

  // Run the divider after each load
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= DIV_STEPS;
    end else if (cmd.load) begin
      div_cnt <= DIV_MUL;
    end else if (div_cnt != DIV_STEPS) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Multiply by the reciprocal, take the quotient, then the remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd <= tm1;
    end
    case (div_cnt)
      DIV_MUL: prod <= {{(TIMEOUT_W + 1){1'b0}}, dvd} * {{TIMEOUT_W{1'b0}}, RECIP};
      DIV_QUO: quo  <= prod_sh[TIMEOUT_W-1:0];
      DIV_REM: rem  <= rem_full[SW-1:0];
      default: begin
      end
    endcase
  end

  // Advance the tick and the current slot
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      cur_slot   <= '0;
    end else if (cmd.load && (req_kind_t'(req_type) == REQ_TICK)) begin
      tick_count <= tick_count + TICK_W'(1);
      cur_slot   <= ((tick_count == '1) || (cur_slot == SLOT_LAST)) ? '0 :
                    cur_slot + SW'(1);
    end
  end

  // Track valid bits and the active count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      active_total <= '0;
    end else begin
      if (step && (hit_cancel || expire)) begin
        valid_bits[eval_ix] <= 1'b0;
        active_total        <= active_total - COUNT_W'(1);
      end else if (add_commit) begin
        valid_bits[free_ix] <= 1'b1;
        active_total        <= active_total + COUNT_W'(1);
      end
    end
  end

  // Write and read the entry pool
  always_ff @(posedge clk) begin
    if (add_commit) begin
      mem_action[free_ix] <= req_action;
      mem_handle[free_ix] <= req_handle;
      mem_slot[free_ix]   <= slot_new;
      mem_rounds[free_ix] <= rounds_new;
    end else if (step && hit_tick && !expire) begin
      mem_rounds[eval_ix] <= rd_rounds - ROUNDS_W'(1);
    end
    if (rd_en) begin
      rd_action <= mem_action[idx[IW-1:0]];
      rd_handle <= mem_handle[idx[IW-1:0]];
      rd_slot   <= mem_slot[idx[IW-1:0]];
      rd_rounds <= mem_rounds[idx[IW-1:0]];
    end
  end

  // Step the scan through the pool
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      eval_valid <= 1'b0;
      found      <= 1'b0;
      cancel_cnt <= '0;
    end else if (cmd.load) begin
      idx        <= '0;
      eval_valid <= 1'b0;
      found      <= 1'b0;
      cancel_cnt <= '0;
    end else if (step) begin
      eval_valid <= rd_en;
      if (rd_en) begin
        idx <= idx + CW'(1);
      end
      if (hit_free) begin
        found <= 1'b1;
      end
      if (hit_cancel) begin
        cancel_cnt <= cancel_cnt + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      eval_ix <= idx[IW-1:0];
    end
    if (step && hit_free) begin
      free_ix <= eval_ix;
    end
  end

  // Hold the result register until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((step && emit_fire) || cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit_fire) begin
      result_kind  <= RES_FIRE;
      status       <= 1'b0;
      fired_action <= rd_action;
      fired_handle <= rd_handle;
      count        <= '0;
      tick_now     <= tick_count;
      last         <= 1'b0;
    end else if (cmd.finish) begin
      status       <= 1'b0;
      fired_action <= '0;
      fired_handle <= '0;
      count        <= '0;
      tick_now     <= tick_count;
      last         <= 1'b1;
      case (req_kind)
        REQ_ADD: begin
          result_kind <= RES_ADD;
          status      <= !found;
        end
        REQ_CANCEL: begin
          result_kind <= RES_CANCEL;
          count       <= cancel_cnt;
        end
        default: begin
          result_kind <= RES_DONE;
          count       <= active_total;
        end
      endcase
    end
  end

  // Report status to the controller
  always_comb begin
    st.div_done  = (div_cnt == DIV_STEPS);
    st.scan_done = (idx == ENTRIES_C) && !eval_valid;
    st.out_free  = out_free;
  end

endmodule

// ===== verif/tb_hashed_timer_wheel.sv =====
// Self-checking testbench for the hashed timer wheel
`timescale 1ns / 1ps
module tb_hashed_timer_wheel;
  import htw_pkg::*;

  localparam int SLOT_W     = $clog2(SLOTS_DEF);
  localparam int QUIET_STOP = 4000;
  localparam int DRAIN_WAIT = 60;

  typedef struct {
    req_kind_t               kind;
    logic [ACTION_W-1:0]     act;
    logic [HANDLE_W-1:0]     owner;
    logic [TIMEOUT_W-1:0]    tmo;
  } wheel_req_t;

  typedef struct {
    res_kind_t               kind;
    logic                    status;
    logic [ACTION_W-1:0]     act;
    logic [HANDLE_W-1:0]     owner;
    logic [COUNT_W-1:0]      cnt;
    logic [TICK_W-1:0]       tick;
    logic                    last;
  } wheel_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [1:0]            req_type = REQ_NOP;
  logic [ACTION_W-1:0]   action = '0;
  logic [HANDLE_W-1:0]   handle = '0;
  logic [TIMEOUT_W-1:0]  timeout = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [1:0]            result_kind;
  logic                  status;
  logic [ACTION_W-1:0]   fired_action;
  logic [HANDLE_W-1:0]   fired_handle;
  logic [COUNT_W-1:0]    count;
  logic [TICK_W-1:0]     tick_now;
  logic                  last;

  // Pending requests, outstanding results and bookkeeping
  wheel_req_t pending_reqs[$];
  wheel_res_t due_results[$];
  int         mismatches = 0;
  int         quiet_cycles = 0;
  int         calm_tail = 0;
  logic       calm = 1'b0;
  logic       req_took = 1'b0;
  int         req_gap = 0;
  int         stall_left = 0;

  // Shadow copy of the wheel
  logic                  wheel_live[ENTRIES_DEF];
  logic [ACTION_W-1:0]   wheel_act[ENTRIES_DEF];
  logic [HANDLE_W-1:0]   wheel_owner[ENTRIES_DEF];
  logic [SLOT_W-1:0]     wheel_slot[ENTRIES_DEF];
  logic [ROUNDS_W-1:0]   wheel_rounds[ENTRIES_DEF];
  logic [TICK_W-1:0]     wheel_ticks = '0;
  logic [COUNT_W-1:0]    wheel_active = '0;

  hashed_timer_wheel uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .action       (action),
    .handle       (handle),
    .timeout      (timeout),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result_kind  (result_kind),
    .status       (status),
    .fired_action (fired_action),
    .fired_handle (fired_handle),
    .count        (count),
    .tick_now     (tick_now),
    .last         (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      wheel_live[i] = 1'b0;
    end
  end

  function automatic void queue_req(req_kind_t kind, logic [ACTION_W-1:0] act,
                                    logic [HANDLE_W-1:0] owner,
                                    logic [TIMEOUT_W-1:0] tmo);
    wheel_req_t r;
    r.kind  = kind;
    r.act   = act;
    r.owner = owner;
    r.tmo   = tmo;
    pending_reqs.push_back(r);
  endfunction

  // Mostly a few shared owners so that cancels find matches
  function automatic logic [HANDLE_W-1:0] pick_owner();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return HANDLE_W'($urandom_range(0, 3));
    if (r < 8) return '1;
    return HANDLE_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Mostly short timeouts so that timers expire within the run
  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return TIMEOUT_W'($urandom_range(0, 12));
    if (r < 8) return TIMEOUT_W'($urandom_range(13, 600));
    return TIMEOUT_W'($urandom_range(0, 24'hFFFFFF));
  endfunction

  function automatic void push_due(res_kind_t kind, logic st, logic [ACTION_W-1:0] act,
                                   logic [HANDLE_W-1:0] owner, logic [COUNT_W-1:0] cnt,
                                   logic lst);
    wheel_res_t w;
    w.kind   = kind;
    w.status = st;
    w.act    = act;
    w.owner  = owner;
    w.cnt    = cnt;
    w.tick   = wheel_ticks;
    w.last   = lst;
    due_results.push_back(w);
  endfunction

  // Apply one accepted request to the shadow wheel and queue the results it causes
  function automatic void compute_wheel_results(req_kind_t kind, logic [ACTION_W-1:0] act,
                                                logic [HANDLE_W-1:0] owner,
                                                logic [TIMEOUT_W-1:0] tmo);
    int          free_ix;
    int          freed;
    int unsigned span;
    int unsigned rnd;
    int unsigned now_slot;
    free_ix = -1;
    freed   = 0;
    case (kind)
      REQ_ADD: begin
        for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
          if (!wheel_live[i]) free_ix = i;
        end
        if (free_ix < 0) begin
          push_due(RES_ADD, 1'b1, '0, '0, '0, 1'b1);
        end else begin
          span = (tmo == '0) ? 1 : 32'(tmo);
          rnd  = (span - 1) / SLOTS_DEF;
          if (rnd > 16'hFFFF) rnd = 16'hFFFF;
          now_slot = wheel_ticks % SLOTS_DEF;
          wheel_live[free_ix]   = 1'b1;
          wheel_act[free_ix]    = act;
          wheel_owner[free_ix]  = owner;
          wheel_slot[free_ix]   = SLOT_W'((now_slot + ((span - 1) % SLOTS_DEF) + 1)
                                          % SLOTS_DEF);
          wheel_rounds[free_ix] = ROUNDS_W'(rnd);
          wheel_active++;
          push_due(RES_ADD, 1'b0, '0, '0, '0, 1'b1);
        end
      end
      REQ_CANCEL: begin
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (wheel_live[i] && wheel_owner[i] == owner) begin
            wheel_live[i] = 1'b0;
            freed++;
          end
        end
        wheel_active -= COUNT_W'(freed);
        push_due(RES_CANCEL, 1'b0, '0, '0, COUNT_W'(freed), 1'b1);
      end
      REQ_TICK: begin
        wheel_ticks++;
        now_slot = wheel_ticks % SLOTS_DEF;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (wheel_live[i] && wheel_slot[i] == now_slot) begin
            if (wheel_rounds[i] != 0) begin
              wheel_rounds[i]--;
            end else begin
              wheel_live[i] = 1'b0;
              wheel_active--;
              // null owner expires silently
              if (wheel_owner[i] != 0)
                push_due(RES_FIRE, 1'b0, wheel_act[i], wheel_owner[i], '0, 1'b0);
            end
          end
        end
        push_due(RES_DONE, 1'b0, '0, '0, wheel_active, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(input string what, input longint unsigned want_v,
                             input longint unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // Drive request transactions at the falling edge; hold a stalled payload
  always @(negedge clk) begin : drive_req
    wheel_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      calm <= (pending_reqs.size() <= calm_tail);
      if (!req_valid || req_took) begin
        if (req_gap > 0) begin
          req_gap   <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          req_gap   <= $urandom_range(0, 13);
          req_valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          req_valid <= 1'b1;
          req_type  <= nxt.kind;
          action    <= nxt.act;
          handle    <= nxt.owner;
          timeout   <= nxt.tmo;
        end
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      res_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Check results, predict accepted requests and watch for a hang
  always @(posedge clk) begin : watch_ports
    wheel_res_t want;
    if (rst) begin
      req_took     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_took <= req_valid && !req_stall;
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result expected none actual kind %0d", $time, result_kind);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(result_kind));
          check_field("status", 64'(want.status), 64'(status));
          check_field("fired_action", 64'(want.act), 64'(fired_action));
          check_field("fired_handle", 64'(want.owner), 64'(fired_handle));
          check_field("count", 64'(want.cnt), 64'(count));
          check_field("tick_now", 64'(want.tick), 64'(tick_now));
          check_field("last", 64'(want.last), 64'(last));
        end
      end
      if (req_valid && !req_stall)
        compute_wheel_results(req_kind_t'(req_type), action, handle, timeout);
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_STOP) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Build the request list, release reset and wait for the wheel to drain
  initial begin : stimulus
    logic [HANDLE_W-1:0] fill_owner;
    int                  pick;

    // Empty wheel, then timers of every flavour, two busy ticks, a NOP, and further cancels and adds
    queue_req(REQ_CANCEL, 8'h00, 16'h0000, 24'h000000);
    queue_req(REQ_TICK,   8'h00, 16'h0000, 24'h000000);
    queue_req(REQ_ADD,    8'hFF, 16'hFFFF, 24'h000000);
    queue_req(REQ_ADD,    8'h11, 16'h0000, 24'h000001);
    queue_req(REQ_ADD,    8'hA5, 16'h5A5A, 24'h000002);
    queue_req(REQ_ADD,    8'h42, 16'h1234, 24'hFFFFFF);
    queue_req(REQ_ADD,    8'h01, 16'h0001, 24'd257);
    queue_req(REQ_ADD,    8'h02, 16'h0001, 24'd256);
    queue_req(REQ_ADD,    8'h3C, 16'h8000, 24'h000001);
    queue_req(REQ_TICK,   8'h00, 16'h0000, 24'h000000);
    queue_req(REQ_TICK,   8'hFF, 16'hFFFF, 24'hFFFFFF);
    queue_req(REQ_NOP,    8'hFF, 16'hFFFF, 24'hFFFFFF);
    queue_req(REQ_CANCEL, 8'h00, 16'hBEAD, 24'h000000);
    queue_req(REQ_CANCEL, 8'h00, 16'h1234, 24'h000000);
    queue_req(REQ_CANCEL, 8'h00, 16'h0001, 24'h000000);
    queue_req(REQ_ADD,    8'h10, 16'h0000, 24'd5);
    queue_req(REQ_ADD,    8'h20, 16'h0000, 24'd6);
    queue_req(REQ_ADD,    8'h30, 16'h0000, 24'd7);
    queue_req(REQ_CANCEL, 8'h00, 16'h0000, 24'h000000);

    // Fill the pool with one owner past full, tick it, then cancel the lot
    fill_owner = HANDLE_W'($urandom_range(0, 16'hFFFF));
    for (int i = 0; i < ENTRIES_DEF + 2; i++) begin
      queue_req(REQ_ADD, ACTION_W'($urandom_range(0, 255)), fill_owner,
                TIMEOUT_W'($urandom_range(700, 24'hFFFFFF)));
    end
    queue_req(REQ_TICK, ACTION_W'($urandom_range(0, 255)),
              HANDLE_W'($urandom_range(0, 16'hFFFF)),
              TIMEOUT_W'($urandom_range(0, 24'hFFFFFF)));
    queue_req(REQ_CANCEL, ACTION_W'($urandom_range(0, 255)), fill_owner,
              TIMEOUT_W'($urandom_range(0, 24'hFFFFFF)));

    // Mixed traffic of adds, ticks, cancels and NOPs over a few owners
    for (int n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38)
        queue_req(REQ_ADD, ACTION_W'($urandom_range(0, 255)), pick_owner(),
                  pick_timeout());
      else if (pick < 76)
        queue_req(REQ_TICK, ACTION_W'($urandom_range(0, 255)),
                  HANDLE_W'($urandom_range(0, 16'hFFFF)),
                  TIMEOUT_W'($urandom_range(0, 24'hFFFFFF)));
      else if (pick < 95)
        queue_req(REQ_CANCEL, ACTION_W'($urandom_range(0, 255)), pick_owner(),
                  TIMEOUT_W'($urandom_range(0, 24'hFFFFFF)));
      else
        queue_req(REQ_NOP, ACTION_W'($urandom_range(0, 255)),
                  HANDLE_W'($urandom_range(0, 16'hFFFF)),
                  TIMEOUT_W'($urandom_range(0, 24'hFFFFFF)));
    end
    calm_tail = 20;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || due_results.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
